// ----- sv/service_level_monitor_core_defines.svh -----
// Assertion macros shared by the service level monitor.
`ifndef SERVICE_LEVEL_MONITOR_CORE_DEFINES_SVH
`define SERVICE_LEVEL_MONITOR_CORE_DEFINES_SVH
// A clocked check that is held off during reset.
`define SLM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// A condition that must never be seen outside reset.
`define SLM_NEVER(label, cond, msg) \
   `SLM_ASSERT(label, !(cond), msg)
`endif

// ----- sv/slm_pkg.sv -----
// Package with the types, constants and sizes of the service level monitor.
`default_nettype none
package slm_pkg;
   localparam int RING_DEPTH   = 32;
   localparam int TABLE_DEPTH  = 16;
   localparam int MAX_DISTINCT = 5;
   localparam int RING_AW      = $clog2(RING_DEPTH);
   localparam int TAB_AW       = $clog2(TABLE_DEPTH);
   localparam int DIST_W       = $clog2(MAX_DISTINCT + 1);
   localparam int NOTOK_W      = $clog2(RING_DEPTH + 1);
   localparam int TICK_STEPS   = ((RING_DEPTH > 32) ? RING_DEPTH : 32) + 1;
   localparam int CNT_W        = $clog2(TICK_STEPS + 1);
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [1:0] ACT_ANCHOR   = 2'd0;
   localparam logic [1:0] ACT_MESSAGE  = 2'd1;
   localparam logic [1:0] ACT_INTERNAL = 2'd2;
   localparam logic [1:0] ACT_TICK     = 2'd3;

   localparam logic [1:0] LVL_LOW  = 2'd0;
   localparam logic [1:0] LVL_MED  = 2'd1;
   localparam logic [1:0] LVL_HIGH = 2'd2;

   localparam logic [1:0] KIND_OK = 2'd0;

   localparam logic [2:0] REG_FRESH     = 3'd0;
   localparam logic [2:0] REG_VANISH    = 3'd1;
   localparam logic [2:0] REG_PERIOD    = 3'd2;
   localparam logic [2:0] REG_BROADCAST = 3'd3;
   localparam logic [2:0] REG_DECISION  = 3'd4;
   localparam logic [2:0] REG_BAD_LIMIT = 3'd5;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] now_ms;
      logic [7:0]  id;
      logic [1:0]  kind;
      logic [1:0]  level;
      logic [31:0] stamp_ms;
      logic [31:0] global_time_ms;
      logic        stale;
   } slm_op_type;

   typedef struct packed {
      logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
      logic                             full;
   } slm_queue_status_type;
endpackage
`default_nettype wire

// ----- sv/slm_interfaces.sv -----
// Channel interfaces of the service level monitor.
`default_nettype none
interface slm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] now_ms;
   logic [7:0]  anchor_id;
   logic [1:0]  report_kind;
   logic [7:0]  node_id;
   logic [1:0]  los_value;
   logic [31:0] stamp_ms;
   logic [31:0] global_time_ms;
   logic        stale_neighbour;
   modport source (output valid, action, now_ms, anchor_id, report_kind, node_id,
                   los_value, stamp_ms, global_time_ms, stale_neighbour, input ready);
   modport sink (input valid, action, now_ms, anchor_id, report_kind, node_id,
                 los_value, stamp_ms, global_time_ms, stale_neighbour, output ready);
endinterface

interface slm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] global_level;
   logic [1:0] local_level;
   modport source (output valid, global_level, local_level, input ready);
   modport sink (input valid, global_level, local_level, output ready);
endinterface

interface slm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/slm_front.sv -----
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none
module slm_front (
   input  wire                          clock,
   input  wire                          reset,
   slm_req_if.sink                      req_if,
   output slm_pkg::slm_op_type          op_out,
   output logic                         op_valid,
   input  wire                          op_pop,
   output slm_pkg::slm_queue_status_type q_status
);
   import slm_pkg::*;

   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   slm_op_type       queue_ff [QUEUE_DEPTH];
   logic [QA_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]  count_ff, count_in;
   slm_op_type       entry;
   logic             push, pop;

   always_comb begin
      entry.action         = req_if.action;
      entry.now_ms         = req_if.now_ms;
      entry.id             = (req_if.action == ACT_ANCHOR) ? req_if.anchor_id : req_if.node_id;
      entry.kind           = req_if.report_kind;
      entry.level          = (req_if.los_value == 2'd3) ? LVL_HIGH : req_if.los_value;
      entry.stamp_ms       = req_if.stamp_ms;
      entry.global_time_ms = req_if.global_time_ms;
      entry.stale          = req_if.stale_neighbour;
   end

   assign req_if.ready = (count_ff != QC_W'(QUEUE_DEPTH));
   assign push = req_if.valid && req_if.ready;
   assign pop  = op_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QC_W'(push) - QC_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   assign op_out         = queue_ff[rd_ptr_ff];
   assign op_valid       = (count_ff != '0);
   assign q_status.count = count_ff;
   assign q_status.full  = !req_if.ready;
endmodule
`default_nettype wire

// ----- sv/slm_back.sv -----
// Back end: holds the ring, the neighbour table and the levels, and runs each action.
`default_nettype none
module slm_back (
   input  wire                 clock,
   input  wire                 reset,
   input  slm_pkg::slm_op_type op_in,
   input  wire                 op_valid,
   output logic                op_pop,
   slm_csr_if.sink             csr_if,
   slm_rsp_if.source           rsp_if
);
   import slm_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FIND   = 3'd1;
   localparam logic [2:0] ST_MIN    = 3'd2;
   localparam logic [2:0] ST_TICK   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;
   localparam logic [2:0] ST_OUT    = 3'd5;

   logic [2:0]  state_ff, state_in;
   slm_op_type  op_ff;

   logic [15:0] fresh_ff, vanish_ff, period_ff, bcast_ff, decide_ff;
   logic [6:0]  bad_limit_ff;

   logic [41:0]        ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] ring_written_ff;
   logic [RING_AW-1:0] ring_wpos_ff;
   logic [41:0]        ring_rd_ff;
   logic               rd_written_ff, rd_valid_ff;

   logic [TABLE_DEPTH-1:0] tab_valid_ff;
   logic [7:0]  tab_id_ff    [TABLE_DEPTH];
   logic [1:0]  tab_level_ff [TABLE_DEPTH];
   logic [31:0] tab_stamp_ff [TABLE_DEPTH];
   logic [TAB_AW-1:0] idx_ff;
   logic [1:0]  best_ff, best_in;

   logic [CNT_W-1:0]   cnt_ff;
   logic [16:0]        rem_ff, rem_in, rem_shift;
   logic [7:0]         ids_ff [MAX_DISTINCT];
   logic [DIST_W-1:0]  distinct_ff;
   logic [NOTOK_W-1:0] notok_ff;
   logic               seen;

   logic [1:0]  received_ff, internal_ff, local_ff, global_ff, next_global_ff, majority_ff;
   logic [15:0] votes_ff [3];
   logic        local_decided_ff, global_decided_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_global_ff, rsp_local_ff;

   logic [15:0] period_eff;
   logic [16:0] left;
   logic [1:0]  grade, capped, majority_new;
   logic        slot_match, out_load;
   logic [7:0]  rd_id;
   logic [1:0]  rd_kind;
   logic [31:0] rd_stamp;

   assign csr_if.ready = 1'b1;
   assign period_eff   = (period_ff == 16'd0) ? 16'd1 : period_ff;
   assign rd_id    = ring_rd_ff[41:34];
   assign rd_kind  = ring_rd_ff[33:32];
   assign rd_stamp = ring_rd_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff     <= 16'd1500;
         vanish_ff    <= 16'd5000;
         period_ff    <= 16'd3000;
         bcast_ff     <= 16'd1000;
         decide_ff    <= 16'd500;
         bad_limit_ff <= 7'd15;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            REG_FRESH:     fresh_ff     <= csr_if.data;
            REG_VANISH:    vanish_ff    <= csr_if.data;
            REG_PERIOD:    period_ff    <= csr_if.data;
            REG_BROADCAST: bcast_ff     <= csr_if.data;
            REG_DECISION:  decide_ff    <= csr_if.data;
            REG_BAD_LIMIT: bad_limit_ff <= csr_if.data[6:0];
            default: ;
         endcase
      end
   end

   assign slot_match = !tab_valid_ff[idx_ff] || (tab_id_ff[idx_ff] == op_ff.id)
                       || (tab_id_ff[idx_ff] == 8'd0);

   always_comb begin
      best_in = best_ff;
      if (tab_valid_ff[idx_ff] && (tab_level_ff[idx_ff] < best_ff)
          && ((op_ff.now_ms - tab_stamp_ff[idx_ff]) < {16'd0, vanish_ff})) begin
         best_in = tab_level_ff[idx_ff];
      end
   end

   assign rem_shift = {rem_ff[15:0], op_ff.global_time_ms[5'(31 - cnt_ff)]};
   assign rem_in    = (rem_shift >= {1'b0, period_eff}) ? rem_shift - {1'b0, period_eff}
                                                         : rem_shift;

   always_comb begin
      seen = 1'b0;
      for (int j = 0; j < MAX_DISTINCT; j++) begin
         if ((DIST_W'(j) < distinct_ff) && (ids_ff[j] == rd_id)) begin
            seen = 1'b1;
         end
      end
   end

   always_comb begin
      if (distinct_ff >= DIST_W'(4)) begin
         grade = (16'(notok_ff) < 16'(bad_limit_ff)) ? LVL_HIGH : LVL_MED;
      end else if (distinct_ff == DIST_W'(3)) begin
         grade = (16'(notok_ff) < 16'(bad_limit_ff)) ? LVL_MED : LVL_LOW;
      end else begin
         grade = LVL_LOW;
      end
      capped = (grade > internal_ff) ? internal_ff : grade;
      if (op_ff.stale && (capped > LVL_MED)) begin
         capped = LVL_MED;
      end
      left = {1'b0, period_eff} - rem_ff;
      majority_new = LVL_LOW;
      if (votes_ff[1] > votes_ff[0]) begin
         majority_new = LVL_MED;
      end
      if (votes_ff[2] > ((votes_ff[1] > votes_ff[0]) ? votes_ff[1] : votes_ff[0])) begin
         majority_new = LVL_HIGH;
      end
   end

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_if.ready);
   assign op_pop   = (state_ff == ST_IDLE) && op_valid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               case (op_in.action)
                  ACT_MESSAGE: state_in = ST_FIND;
                  ACT_TICK:    state_in = ST_TICK;
                  default:     state_in = ST_OUT;
               endcase
            end
         end
         ST_FIND: begin
            if (slot_match || (idx_ff == TAB_AW'(TABLE_DEPTH - 1))) begin
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            if (idx_ff == TAB_AW'(TABLE_DEPTH - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_TICK: begin
            if (cnt_ff == CNT_W'(TICK_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_OUT;
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         op_ff <= op_in;
      end
      if (op_pop && (op_in.action == ACT_ANCHOR)) begin
         ring_mem[ring_wpos_ff] <= {op_in.id, op_in.kind, op_in.stamp_ms};
      end
      ring_rd_ff    <= ring_mem[cnt_ff[RING_AW-1:0]];
      rd_written_ff <= ring_written_ff[cnt_ff[RING_AW-1:0]];
      if ((state_ff == ST_FIND) && slot_match) begin
         tab_id_ff[idx_ff]    <= op_ff.id;
         tab_level_ff[idx_ff] <= op_ff.level;
         tab_stamp_ff[idx_ff] <= op_ff.stamp_ms;
      end
      if ((state_ff == ST_TICK) && rd_valid_ff && rd_written_ff && (rd_kind == KIND_OK)
          && ((op_ff.now_ms - rd_stamp) < {16'd0, fresh_ff})
          && (distinct_ff < DIST_W'(MAX_DISTINCT)) && !seen) begin
         ids_ff[distinct_ff[$clog2(MAX_DISTINCT)-1:0]] <= rd_id;
      end
      if (op_pop) begin
         rem_ff <= '0;
      end else if ((state_ff == ST_TICK) && (cnt_ff < CNT_W'(32))) begin
         rem_ff <= rem_in;
      end
      if (op_pop) begin
         best_ff <= LVL_HIGH;
      end else if (state_ff == ST_MIN) begin
         best_ff <= best_in;
      end
      if (out_load) begin
         rsp_global_ff <= global_ff;
         rsp_local_ff  <= local_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         ring_written_ff   <= '0;
         ring_wpos_ff      <= '0;
         rd_valid_ff       <= 1'b0;
         tab_valid_ff      <= '0;
         idx_ff            <= '0;
         cnt_ff            <= '0;
         distinct_ff       <= '0;
         notok_ff          <= '0;
         received_ff       <= LVL_HIGH;
         internal_ff       <= LVL_HIGH;
         local_ff          <= LVL_HIGH;
         global_ff         <= LVL_HIGH;
         next_global_ff    <= LVL_HIGH;
         majority_ff       <= LVL_HIGH;
         votes_ff[0]       <= '0;
         votes_ff[1]       <= '0;
         votes_ff[2]       <= '0;
         local_decided_ff  <= 1'b0;
         global_decided_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == ST_TICK) && (cnt_ff < CNT_W'(RING_DEPTH));
         if (op_pop) begin
            idx_ff      <= '0;
            cnt_ff      <= '0;
            distinct_ff <= '0;
            notok_ff    <= '0;
            if (op_in.action == ACT_ANCHOR) begin
               ring_written_ff[ring_wpos_ff] <= 1'b1;
               ring_wpos_ff <= (ring_wpos_ff == RING_AW'(RING_DEPTH - 1)) ? '0
                                                                         : ring_wpos_ff + 1'b1;
            end
            if (op_in.action == ACT_INTERNAL) begin
               internal_ff <= op_in.level;
            end
         end
         case (state_ff)
            ST_FIND: begin
               if (slot_match) begin
                  tab_valid_ff[idx_ff] <= 1'b1;
                  idx_ff <= '0;
               end else if (idx_ff != TAB_AW'(TABLE_DEPTH - 1)) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  idx_ff <= '0;
               end
            end
            ST_MIN: begin
               if (idx_ff == TAB_AW'(TABLE_DEPTH - 1)) begin
                  received_ff <= best_in;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_TICK: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (rd_valid_ff && rd_written_ff) begin
                  if ((rd_kind == KIND_OK)
                      && ((op_ff.now_ms - rd_stamp) < {16'd0, fresh_ff})
                      && (distinct_ff < DIST_W'(MAX_DISTINCT)) && !seen) begin
                     distinct_ff <= distinct_ff + 1'b1;
                  end
                  if (rd_kind > 2'd1) begin
                     notok_ff <= notok_ff + 1'b1;
                  end
               end
            end
            ST_FINISH: begin
               if (left > {1'b0, bcast_ff}) begin
                  local_ff <= capped;
                  if (votes_ff[capped] != 16'hFFFF) begin
                     votes_ff[capped] <= votes_ff[capped] + 1'b1;
                  end
                  global_ff        <= next_global_ff;
                  local_decided_ff <= 1'b0;
               end else if (!local_decided_ff) begin
                  majority_ff       <= majority_new;
                  local_ff          <= majority_new;
                  votes_ff[0]       <= '0;
                  votes_ff[1]       <= '0;
                  votes_ff[2]       <= '0;
                  local_decided_ff  <= 1'b1;
                  global_decided_ff <= (left < {1'b0, decide_ff});
                  if (left < {1'b0, decide_ff}) begin
                     next_global_ff <= (majority_new < received_ff) ? majority_new : received_ff;
                  end
               end else begin
                  local_ff <= majority_ff;
                  if ((left < {1'b0, decide_ff}) && !global_decided_ff) begin
                     next_global_ff    <= (majority_ff < received_ff) ? majority_ff : received_ff;
                     global_decided_ff <= 1'b1;
                  end
               end
            end
            default: ;
         endcase
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.global_level = rsp_global_ff;
   assign rsp_if.local_level  = rsp_local_ff;
endmodule
`default_nettype wire

// ----- sv/service_level_monitor_core.sv -----
// Top level of the service level monitor: front end, request queue and back end.
// The req_ channel carries one action per transfer: anchor report, neighbour
// message, internal level or tick. Every accepted transfer yields exactly one
// transfer on the rsp_ channel with the global and local level after the action.
// The csr_ channel writes the six limit registers; it is always ready. It is
// only to be written while the block is idle; the block does not enforce this.
// An anchor report or internal level goes from idle straight to the result
// state. A neighbour message walks the neighbour table, first for a free or
// matching slot and then for the minimum. A tick walks the 32 ring entries
// through the ring memory read port beside a one-bit-per-cycle modulo unit,
// then passes a finish state before the result state.
// Items are carried out one at a time; a two-entry queue keeps accepting while
// the back end works. Reset clears the ring and table valid bits at once, sets
// all levels to high and loads the default limits. When the receiver stalls,
// the result register holds, the back end waits and the queue fills, after
// which req_if.ready falls.
`default_nettype none
module service_level_monitor_core (
   input  wire       clock,
   input  wire       reset,
   slm_req_if.sink   req_if,
   slm_rsp_if.source rsp_if,
   slm_csr_if.sink   csr_if
);
   import slm_pkg::*;
   `include "service_level_monitor_core_defines.svh"

   slm_op_type           op;
   logic                 op_valid, op_pop;
   slm_queue_status_type q_status;
   logic                 level_bad;

   slm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .op_out   (op),
      .op_valid (op_valid),
      .op_pop   (op_pop),
      .q_status (q_status)
   );

   slm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_in    (op),
      .op_valid (op_valid),
      .op_pop   (op_pop),
      .csr_if   (csr_if),
      .rsp_if   (rsp_if)
   );

   assign level_bad = (rsp_if.global_level > LVL_HIGH) || (rsp_if.local_level > LVL_HIGH);

   `SLM_NEVER(a_queue_bound, q_status.count > 2'(QUEUE_DEPTH), "request queue overflow")
   `SLM_NEVER(a_pop_empty, op_pop && !op_valid, "pop from an empty queue")
   `SLM_NEVER(a_level_code, rsp_if.valid && level_bad, "level code out of range")
   `SLM_ASSERT(a_rsp_hold, rsp_if.valid && !rsp_if.ready |=> rsp_if.valid, "result dropped")
endmodule
`default_nettype wire

// ----- tb/service_level_monitor_core_tb.sv -----
// Self-checking testbench of the service level monitor with a built-in level predictor.
`default_nettype none
module service_level_monitor_core_tb;
   import slm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0] global_level;
      logic [1:0] local_level;
   } level_pair_type;

   typedef struct {
      bit          written;
      logic [7:0]  id;
      logic [1:0]  kind;
      logic [31:0] stamp;
   } anchor_entry_type;

   typedef struct {
      bit          valid;
      logic [7:0]  id;
      logic [1:0]  level;
      logic [31:0] stamp;
   } neighbour_slot_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slm_req_if req_if ();
   slm_rsp_if rsp_if ();
   slm_csr_if csr_if ();

   service_level_monitor_core DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source),
      .csr_if(csr_if.sink)
   );

   always #6 clock = ~clock;

   // Predictor state.
   logic [31:0]        lim_fresh, lim_vanish, lim_period, lim_broadcast, lim_decision;
   logic [31:0]        lim_bad;
   anchor_entry_type   anchors [RING_DEPTH];
   int unsigned        anchor_wr;
   neighbour_slot_type neighbours [TABLE_DEPTH];
   logic [1:0]         rx_level, int_level, loc_level, glob_level, next_glob, maj_level;
   logic [15:0]        votes [3];
   bit                 loc_decided, glob_decided;

   level_pair_type expected_levels [$];
   int          error_count = 0;
   int          result_count = 0;
   int          item_count = 0;
   int          tick_count = 0;
   logic [31:0] clk_ms = 32'd0;

   function automatic logic [1:0] grade_anchors(logic [31:0] now);
      logic [7:0]  ids [MAX_DISTINCT];
      int          distinct;
      int          not_ok;
      bit          seen;
      distinct = 0;
      not_ok = 0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         if (!anchors[i].written) continue;
         if ((now - anchors[i].stamp) < lim_fresh && anchors[i].kind == KIND_OK &&
             distinct < MAX_DISTINCT) begin
            seen = 0;
            for (int j = 0; j < distinct; j++)
               if (ids[j] == anchors[i].id) seen = 1;
            if (!seen) begin
               ids[distinct] = anchors[i].id;
               distinct++;
            end
         end
         if (anchors[i].kind > 2'd1) not_ok++;
      end
      if (distinct >= 4) return (not_ok < lim_bad) ? LVL_HIGH : LVL_MED;
      if (distinct == 3) return (not_ok < lim_bad) ? LVL_MED : LVL_LOW;
      return LVL_LOW;
   endfunction

   task automatic predict_levels(input slm_op_type op);
      logic [1:0]  lvl;
      logic [31:0] per, left;
      logic [15:0] best;
      lvl = (op.level == 2'd3) ? LVL_HIGH : op.level;
      case (op.action)
         ACT_ANCHOR: begin
            anchors[anchor_wr] = '{1'b1, op.id, op.kind, op.stamp_ms};
            anchor_wr = (anchor_wr + 1) % RING_DEPTH;
         end
         ACT_MESSAGE: begin
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (!neighbours[i].valid || neighbours[i].id == op.id ||
                   neighbours[i].id == 8'd0) begin
                  neighbours[i] = '{1'b1, op.id, lvl, op.stamp_ms};
                  break;
               end
            rx_level = LVL_HIGH;
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (neighbours[i].valid && neighbours[i].level < rx_level &&
                   (op.now_ms - neighbours[i].stamp) < lim_vanish)
                  rx_level = neighbours[i].level;
         end
         ACT_INTERNAL: int_level = lvl;
         default: begin
            lvl = grade_anchors(op.now_ms);
            if (lvl > int_level) lvl = int_level;
            if (op.stale && lvl > LVL_MED) lvl = LVL_MED;
            per = (lim_period == 0) ? 32'd1 : lim_period;
            left = per - (op.global_time_ms % per);
            if (left > lim_broadcast) begin
               loc_level = lvl;
               if (votes[lvl] != 16'hFFFF) votes[lvl]++;
               glob_level = next_glob;
               loc_decided = 0;
            end else begin
               if (!loc_decided) begin
                  best = votes[0];
                  maj_level = LVL_LOW;
                  for (int i = 1; i < 3; i++)
                     if (votes[i] > best) begin
                        best = votes[i];
                        maj_level = i[1:0];
                     end
                  votes = '{16'd0, 16'd0, 16'd0};
                  loc_decided = 1;
                  glob_decided = 0;
               end
               loc_level = maj_level;
               if (left < lim_decision && !glob_decided) begin
                  next_glob = (loc_level < rx_level) ? loc_level : rx_level;
                  glob_decided = 1;
               end
            end
         end
      endcase
      expected_levels.push_back('{glob_level, loc_level});
   endtask

   task automatic predictor_reset();
      lim_fresh = 1500; lim_vanish = 5000; lim_period = 3000;
      lim_broadcast = 1000; lim_decision = 500; lim_bad = 15;
      foreach (anchors[i]) anchors[i] = '{1'b0, 8'd0, 2'd0, 32'd0};
      foreach (neighbours[i]) neighbours[i] = '{1'b0, 8'd0, 2'd0, 32'd0};
      anchor_wr = 0;
      rx_level = LVL_HIGH; int_level = LVL_HIGH; loc_level = LVL_HIGH;
      glob_level = LVL_HIGH; next_glob = LVL_HIGH; maj_level = LVL_HIGH;
      votes = '{16'd0, 16'd0, 16'd0};
      loc_decided = 0; glob_decided = 0;
   endtask

   task automatic send_item(input slm_op_type op);
      int idle;
      idle = $urandom_range(0, 6);
      if (idle != 0) begin
         req_if.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.action <= op.action;
      req_if.now_ms <= op.now_ms;
      req_if.anchor_id <= op.id;
      req_if.node_id <= op.id;
      req_if.report_kind <= op.kind;
      req_if.los_value <= op.level;
      req_if.stamp_ms <= op.stamp_ms;
      req_if.global_time_ms <= op.global_time_ms;
      req_if.stale_neighbour <= op.stale;
      do @(posedge clock); while (!req_if.ready);
      predict_levels(op);
      item_count++;
      if (op.action == ACT_TICK) tick_count++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         REG_FRESH:     lim_fresh = 32'(value);
         REG_VANISH:    lim_vanish = 32'(value);
         REG_PERIOD:    lim_period = 32'(value);
         REG_BROADCAST: lim_broadcast = 32'(value);
         REG_DECISION:  lim_decision = 32'(value);
         REG_BAD_LIMIT: lim_bad = 32'(value[6:0]);
         default: ;
      endcase
   endtask

   function automatic slm_op_type make_op(input logic [1:0] act);
      slm_op_type op;
      op.action = act;
      op.now_ms = clk_ms;
      op.id = 8'($urandom_range(0, 7));
      op.kind = 2'($urandom_range(0, 3));
      op.level = 2'($urandom_range(0, 3));
      op.stamp_ms = clk_ms - $urandom_range(0, 3000);
      op.global_time_ms = clk_ms;
      op.stale = ($urandom_range(0, 7) == 0);
      return op;
   endfunction

   // Local time moves ahead by a random step of 0 to 40 ms.
   task automatic send_scenario(input int count, input bit noisy);
      slm_op_type op;
      logic [1:0] act;
      for (int n = 0; n < count; n++) begin
         clk_ms = clk_ms + $urandom_range(0, 40);
         act = 2'($urandom_range(0, 3));
         op = make_op(act);
         if (noisy) begin
            op.now_ms = $urandom;
            op.id = 8'($urandom);
            op.stamp_ms = $urandom;
            op.global_time_ms = $urandom;
            op.stale = 1'($urandom);
         end
         send_item(op);
      end
   endtask

   task automatic test_directed();
      slm_op_type op;
      op = make_op(ACT_TICK);
      op.global_time_ms = 32'd0;
      send_item(op);
      for (int i = 0; i < 5; i++) begin
         op = make_op(ACT_ANCHOR);
         op.id = 8'(8'hFF - i);
         op.kind = KIND_OK;
         op.stamp_ms = clk_ms;
         send_item(op);
      end
      op = make_op(ACT_ANCHOR);
      op.kind = 2'd3;
      op.stamp_ms = 32'hFFFF_FFFF;
      send_item(op);
      op = make_op(ACT_MESSAGE);
      op.id = 8'd0;
      op.level = 2'd3;
      send_item(op);
      op = make_op(ACT_MESSAGE);
      op.id = 8'hFF;
      op.level = LVL_LOW;
      op.stamp_ms = clk_ms;
      send_item(op);
      op = make_op(ACT_INTERNAL);
      op.level = 2'd3;
      send_item(op);
      op = make_op(ACT_INTERNAL);
      op.level = LVL_MED;
      send_item(op);
      foreach (op.global_time_ms[b]) begin
         op = make_op(ACT_TICK);
         op.global_time_ms = 32'(32'd2999 - b);
         op.stale = b[0];
         if (b < 4) send_item(op);
      end
      op = make_op(ACT_TICK);
      op.now_ms = 32'hFFFF_FFFF;
      op.global_time_ms = 32'hFFFF_FFFF;
      send_item(op);
   endtask

   task automatic test_register_settings();
      write_register(REG_PERIOD, 16'd0);
      send_scenario(20, 0);
      write_register(REG_PERIOD, 16'hFFFF);
      write_register(REG_FRESH, 16'hFFFF);
      write_register(REG_VANISH, 16'd0);
      write_register(REG_BROADCAST, 16'hFFFF);
      write_register(REG_DECISION, 16'hFFFF);
      write_register(REG_BAD_LIMIT, 16'd64);
      send_scenario(150, 0);
      write_register(REG_FRESH, 16'd0);
      write_register(REG_BROADCAST, 16'd0);
      write_register(REG_DECISION, 16'd0);
      write_register(REG_BAD_LIMIT, 16'd0);
      send_scenario(150, 0);
      write_register(REG_PERIOD, 16'd200);
      write_register(REG_FRESH, 16'd2000);
      write_register(REG_VANISH, 16'd3000);
      write_register(REG_BROADCAST, 16'd80);
      write_register(REG_DECISION, 16'd40);
      write_register(REG_BAD_LIMIT, 16'd3);
      send_scenario(300, 0);
   endtask

   task automatic test_default_random();
      write_register(REG_FRESH, 16'd1500);
      write_register(REG_VANISH, 16'd5000);
      write_register(REG_PERIOD, 16'd3000);
      write_register(REG_BROADCAST, 16'd1000);
      write_register(REG_DECISION, 16'd500);
      write_register(REG_BAD_LIMIT, 16'd15);
      send_scenario(900, 0);
      wait_drained();
      send_scenario(200, 1);
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.action = ACT_ANCHOR;
      req_if.now_ms = '0;
      req_if.anchor_id = '0;
      req_if.report_kind = '0;
      req_if.node_id = '0;
      req_if.los_value = '0;
      req_if.stamp_ms = '0;
      req_if.global_time_ms = '0;
      req_if.stale_neighbour = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_FRESH;
      csr_if.data = '0;
      predictor_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_settings();
      test_default_random();
      wait_drained();
      $display("Sent %0d items (%0d ticks), checked %0d results over six limit settings.",
               item_count, tick_count, result_count);
      if (error_count == 0 && expected_levels.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      int stall;
      stall = $urandom_range(0, 6);
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            result_count++;
            stall = $urandom_range(0, 6);
            if (expected_levels.size() == 0) begin
               $error("Result transfer with no expected levels waiting.");
               error_count++;
            end else begin
               level_pair_type exp_lv;
               exp_lv = expected_levels.pop_front();
               if (rsp_if.global_level !== exp_lv.global_level) begin
                  $error("global_level expected %0d, actual %0d",
                         exp_lv.global_level, rsp_if.global_level);
                  error_count++;
               end
               if (rsp_if.local_level !== exp_lv.local_level) begin
                  $error("local_level expected %0d, actual %0d",
                         exp_lv.local_level, rsp_if.local_level);
                  error_count++;
               end
            end
         end
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire

// ----- service_level_monitor_core.f -----
+incdir+sv
sv/slm_pkg.sv
sv/slm_interfaces.sv
sv/slm_front.sv
sv/slm_back.sv
sv/service_level_monitor_core.sv
tb/service_level_monitor_core_tb.sv
